### design/sldf_pkg.sv
`default_nettype none

package sldf_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CNT_W  = 16;
    localparam int unsigned CFG_W  = 16;
    localparam int unsigned REPLY_W = 3;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // register indexes on the configuration port
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_BLOCK  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CTS_LIMIT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END_CODE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ESC_CODE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_CODE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CMD_PREFIX = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_EVT_PREFIX = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CTS_CODE   = 3'd7;

    // in-band commands and events
    localparam logic [BYTE_W-1:0] RESET_COMMAND          = 8'd1;
    localparam logic [BYTE_W-1:0] PING_COMMAND           = 8'd4;
    localparam logic [BYTE_W-1:0] RECV_BUF_RESET_COMMAND = 8'd2;
    localparam logic [BYTE_W-1:0] RESET_EVENT            = 8'd1;

    // reply event codes
    localparam logic [REPLY_W-1:0] REPLY_NONE      = 3'd0;
    localparam logic [REPLY_W-1:0] REPLY_RESET     = 3'd1;
    localparam logic [REPLY_W-1:0] REPLY_PING      = 3'd2;
    localparam logic [REPLY_W-1:0] REPLY_BUF_FULL  = 3'd3;
    localparam logic [REPLY_W-1:0] REPLY_TOO_LONG  = 3'd4;

    // queue between the classifier and the counter stage
    localparam int unsigned QDEPTH = 2;
    localparam int unsigned QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int unsigned QCW    = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [BYTE_W-1:0] end_code;
        logic [BYTE_W-1:0] escape_code;
        logic [BYTE_W-1:0] pad_code;
        logic [BYTE_W-1:0] command_prefix;
        logic [BYTE_W-1:0] event_prefix;
        logic [BYTE_W-1:0] cts_code;
    } t_codes;

    // one classified byte, as handed from front to back
    typedef struct packed {
        logic [BYTE_W-1:0]  rx_byte;
        logic               cts_sent;    // clear received count first
        logic               count;       // byte counts towards CTS
        logic               clr_rsc;     // clear received count last
        logic               clr_blk;     // clear block count
        logic               store;       // data byte goes to the store
        logic               held;        // data byte refused, store full
        logic               end_marker;
        logic               command_valid;
        logic               event_valid;
        logic               cts_received;
        logic [REPLY_W-1:0] reply;       // reply from front; too-long added in back
        logic               link_ready;
    } t_op;

endpackage

`default_nettype wire

### design/sldf_front.sv
`default_nettype none

module sldf_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_accept,
    input  wire logic [sldf_pkg::BYTE_W-1:0]   i_rx_byte,
    input  wire logic                          i_buffer_full,
    input  wire logic                          i_cts_was_sent,
    input  wire sldf_pkg::t_codes              i_codes,
    output sldf_pkg::t_op                      o_op
);

    logic r_esc, r_cmd, r_evt, r_rr;
    logic n_esc, n_cmd, n_evt, n_rr;
    logic is_data;

    always_comb begin
        o_op          = '0;
        o_op.rx_byte  = i_rx_byte;
        o_op.cts_sent = i_cts_was_sent;
        o_op.reply    = sldf_pkg::REPLY_NONE;
        n_esc   = r_esc;
        n_cmd   = r_cmd;
        n_evt   = r_evt;
        n_rr    = r_rr;
        is_data = 1'b0;

        if (r_cmd) begin
            o_op.count         = 1'b1;
            o_op.command_valid = 1'b1;
            n_cmd              = 1'b0;
            if (i_rx_byte == sldf_pkg::RESET_COMMAND) begin
                n_rr         = 1'b0;
                n_esc        = 1'b0;
                n_evt        = 1'b0;
                o_op.clr_blk = 1'b1;
                o_op.clr_rsc = 1'b1;
                o_op.reply   = sldf_pkg::REPLY_RESET;
            end else if (i_rx_byte == sldf_pkg::RECV_BUF_RESET_COMMAND) begin
                o_op.clr_blk = 1'b1;
            end else if (i_rx_byte == sldf_pkg::PING_COMMAND) begin
                o_op.reply = sldf_pkg::REPLY_PING;
            end
        end else if (r_evt) begin
            o_op.count       = 1'b1;
            o_op.event_valid = 1'b1;
            n_evt            = 1'b0;
            if (i_rx_byte == sldf_pkg::RESET_EVENT) begin
                o_op.clr_rsc = !r_rr;
                n_rr         = 1'b1;
            end
        end else if (r_esc) begin
            is_data = 1'b1;
        end else if (i_rx_byte == i_codes.end_code) begin
            o_op.count      = 1'b1;
            o_op.end_marker = 1'b1;
            o_op.clr_blk    = 1'b1;
        end else if (i_rx_byte == i_codes.escape_code) begin
            o_op.count = 1'b1;
            n_esc      = 1'b1;
        end else if (i_rx_byte == i_codes.pad_code) begin
            o_op.count = 1'b1;
        end else if (i_rx_byte == i_codes.command_prefix) begin
            o_op.count = 1'b1;
            n_cmd      = 1'b1;
        end else if (i_rx_byte == i_codes.event_prefix) begin
            o_op.count = 1'b1;
            n_evt      = 1'b1;
        end else if (i_rx_byte == i_codes.cts_code) begin
            o_op.count        = 1'b1;
            o_op.cts_received = 1'b1;
        end else begin
            is_data = 1'b1;
        end

        if (is_data) begin
            if (r_rr && i_buffer_full) begin
                // refused: nothing moves, escape stays pending
                o_op.held  = 1'b1;
                o_op.reply = sldf_pkg::REPLY_BUF_FULL;
            end else begin
                o_op.count = 1'b1;
                o_op.store = r_rr;
                n_esc      = 1'b0;
            end
        end

        o_op.link_ready = n_rr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc <= 1'b0;
            r_cmd <= 1'b0;
            r_evt <= 1'b0;
            r_rr  <= 1'b0;
        end else if (i_accept) begin
            r_esc <= n_esc;
            r_cmd <= n_cmd;
            r_evt <= n_evt;
            r_rr  <= n_rr;
        end
    end

    // at most one prefix can be outstanding
    a_one_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({r_esc, r_cmd, r_evt}))
        else $error("more than one prefix pending");

    a_held_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && o_op.held) |=> $stable({r_esc, r_cmd, r_evt, r_rr}))
        else $error("refused byte changed front state");

    a_reset_cmd_drops_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && o_op.command_valid && o_op.reply == sldf_pkg::REPLY_RESET)
        |=> !r_rr)
        else $error("reset command left link ready");

endmodule

`default_nettype wire

### design/sldf_queue.sv
`default_nettype none

module sldf_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire sldf_pkg::t_op i_op,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_valid,
    output sldf_pkg::t_op      o_op
);

    sldf_pkg::t_op                 r_mem [sldf_pkg::QDEPTH];
    logic [sldf_pkg::QAW-1:0]      r_wptr, r_rptr;
    logic [sldf_pkg::QCW-1:0]      r_cnt;

    localparam logic [sldf_pkg::QCW-1:0] DEPTH_C = sldf_pkg::QCW'(sldf_pkg::QDEPTH);
    localparam logic [sldf_pkg::QAW-1:0] LAST_C  = sldf_pkg::QAW'(sldf_pkg::QDEPTH - 1);

    assign o_full  = (r_cnt == DEPTH_C);
    assign o_valid = (r_cnt != '0);
    assign o_op    = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == LAST_C) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == LAST_C) ? '0 : r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue underflow");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= DEPTH_C)
        else $error("queue count out of range");

endmodule

`default_nettype wire

### design/sldf_back.sv
`default_nettype none

module sldf_back (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_q_valid,
    input  wire sldf_pkg::t_op                  i_op,
    output logic                                o_pop,
    input  wire logic [sldf_pkg::CNT_W-1:0]     i_max_block_size,
    input  wire logic [sldf_pkg::CNT_W-1:0]     i_local_cts_limit,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic                                o_consumed,
    output logic                                o_data_valid,
    output logic [sldf_pkg::BYTE_W-1:0]         o_data_byte,
    output logic                                o_end_marker,
    output logic                                o_command_valid,
    output logic [sldf_pkg::BYTE_W-1:0]         o_command_value,
    output logic                                o_event_valid,
    output logic [sldf_pkg::BYTE_W-1:0]         o_event_value,
    output logic                                o_cts_received,
    output logic [sldf_pkg::REPLY_W-1:0]        o_reply_event,
    output logic                                o_cts_due,
    output logic                                o_link_ready
);

    logic [sldf_pkg::CNT_W-1:0] r_blk, r_rsc;
    logic [sldf_pkg::CNT_W-1:0] n_blk, n_rsc;
    logic [sldf_pkg::CNT_W-1:0] rsc_base, rsc_inc;
    logic                       lim_on;
    logic [sldf_pkg::REPLY_W-1:0] n_reply;

    logic                          r_valid;
    logic                          r_consumed, r_data_valid, r_end_marker;
    logic                          r_command_valid, r_event_valid, r_cts_received;
    logic                          r_cts_due, r_link_ready;
    logic [sldf_pkg::BYTE_W-1:0]   r_data_byte, r_command_value, r_event_value;
    logic [sldf_pkg::REPLY_W-1:0]  r_reply_event;

    assign o_pop  = i_q_valid && (!r_valid || i_ready);
    assign lim_on = (i_local_cts_limit != '0);

    always_comb begin
        rsc_base = i_op.cts_sent ? '0 : r_rsc;
        rsc_inc  = (i_op.count && lim_on && rsc_base != sldf_pkg::CNT_MAX)
                 ? sldf_pkg::CNT_W'(rsc_base + 1'b1) : rsc_base;
        n_rsc    = i_op.clr_rsc ? '0 : rsc_inc;

        if (i_op.clr_blk) begin
            n_blk = '0;
        end else if (i_op.store && r_blk != sldf_pkg::CNT_MAX) begin
            n_blk = sldf_pkg::CNT_W'(r_blk + 1'b1);
        end else begin
            n_blk = r_blk;
        end

        n_reply = i_op.reply;
        if (i_op.store && i_max_block_size != '0 && n_blk > i_max_block_size) begin
            n_reply = sldf_pkg::REPLY_TOO_LONG;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_blk   <= '0;
            r_rsc   <= '0;
        end else begin
            if (o_pop) begin
                r_valid <= 1'b1;
                r_blk   <= n_blk;
                r_rsc   <= n_rsc;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_consumed      <= !i_op.held;
            r_data_valid    <= i_op.store;
            r_data_byte     <= i_op.store ? i_op.rx_byte : '0;
            r_end_marker    <= i_op.end_marker;
            r_command_valid <= i_op.command_valid;
            r_command_value <= i_op.command_valid ? i_op.rx_byte : '0;
            r_event_valid   <= i_op.event_valid;
            r_event_value   <= i_op.event_valid ? i_op.rx_byte : '0;
            r_cts_received  <= i_op.cts_received;
            r_reply_event   <= n_reply;
            r_cts_due       <= lim_on && (n_rsc >= i_local_cts_limit);
            r_link_ready    <= i_op.link_ready;
        end
    end

    assign o_valid         = r_valid;
    assign o_consumed      = r_consumed;
    assign o_data_valid    = r_data_valid;
    assign o_data_byte     = r_data_byte;
    assign o_end_marker    = r_end_marker;
    assign o_command_valid = r_command_valid;
    assign o_command_value = r_command_value;
    assign o_event_valid   = r_event_valid;
    assign o_event_value   = r_event_value;
    assign o_cts_received  = r_cts_received;
    assign o_reply_event   = r_reply_event;
    assign o_cts_due       = r_cts_due;
    assign o_link_ready    = r_link_ready;

    a_refused_is_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_consumed) |-> (r_reply_event == sldf_pkg::REPLY_BUF_FULL))
        else $error("refused byte without buffer-full reply");

    a_store_needs_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_data_valid) |-> (r_link_ready && r_consumed))
        else $error("data stored while link not ready");

    a_rsc_off_when_no_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_local_cts_limit == '0 && $past(i_local_cts_limit) == '0
         && $past(i_rst_n) && $past(r_rsc) == '0) |-> (r_rsc == '0))
        else $error("received count moved with counting disabled");

endmodule

`default_nettype wire

### design/stuffed_link_receive_deframer.sv
`default_nettype none

// Receive deframer for a byte-stuffed serial link with in-band flow control.
//
// Input channel (i_valid / o_ready): one received link byte per request, with
// the downstream store's full flag and a "local CTS just sent" strobe.
// Output channel (o_valid / i_ready): exactly one result per input request:
// consumed flag, data byte for the store, end marker, command, event, CTS
// received, reply event, CTS due and link ready.
// Configuration: i_cfg_we writes i_cfg_data to the register at i_cfg_idx in
// the same cycle; write only while no request is in flight.
//
// The result of an accepted request is written into the queue, then into the
// output register, from which it can be taken. Throughput: one request per
// cycle while the receiver takes results. The front classifier updates the
// escape/command/event flags and link-ready; the back stage updates the block
// and received counters; a two-entry queue sits between them.
// Reset (synchronous, active low) clears all flags and counters, empties the
// queue and the output register, and loads the default codes.
// When the receiver stalls, the output register holds its result, the queue
// fills, and o_ready drops once both queue entries are taken.
// A refused data byte (consumed low) must be offered again by the sender.

module stuffed_link_receive_deframer (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration
    input  wire logic                              i_cfg_we,
    input  wire logic [sldf_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [sldf_pkg::CFG_W-1:0]        i_cfg_data,
    // input requests
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic [sldf_pkg::BYTE_W-1:0]       i_rx_byte,
    input  wire logic                              i_buffer_full,
    input  wire logic                              i_cts_was_sent,
    // result requests
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic                                   o_consumed,
    output logic                                   o_data_valid,
    output logic [sldf_pkg::BYTE_W-1:0]            o_data_byte,
    output logic                                   o_end_marker,
    output logic                                   o_command_valid,
    output logic [sldf_pkg::BYTE_W-1:0]            o_command_value,
    output logic                                   o_event_valid,
    output logic [sldf_pkg::BYTE_W-1:0]            o_event_value,
    output logic                                   o_cts_received,
    output logic [sldf_pkg::REPLY_W-1:0]           o_reply_event,
    output logic                                   o_cts_due,
    output logic                                   o_link_ready
);

    // configuration registers
    logic [sldf_pkg::CNT_W-1:0] r_max_block_size;
    logic [sldf_pkg::CNT_W-1:0] r_local_cts_limit;
    sldf_pkg::t_codes           r_codes;

    // front / queue / back wiring
    logic          accept;
    logic          q_full;
    logic          q_valid;
    logic          q_pop;
    sldf_pkg::t_op front_op;
    sldf_pkg::t_op head_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_block_size       <= '0;
            r_local_cts_limit      <= '0;
            r_codes.end_code       <= 8'd0;
            r_codes.escape_code    <= 8'd1;
            r_codes.pad_code       <= 8'd2;
            r_codes.command_prefix <= 8'd3;
            r_codes.event_prefix   <= 8'd4;
            r_codes.cts_code       <= 8'd5;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sldf_pkg::REG_MAX_BLOCK:  r_max_block_size  <= i_cfg_data;
                sldf_pkg::REG_CTS_LIMIT:  r_local_cts_limit <= i_cfg_data;
                sldf_pkg::REG_END_CODE:   r_codes.end_code  <= i_cfg_data[sldf_pkg::BYTE_W-1:0];
                sldf_pkg::REG_ESC_CODE: begin
                    r_codes.escape_code <= i_cfg_data[sldf_pkg::BYTE_W-1:0];
                end
                sldf_pkg::REG_PAD_CODE:   r_codes.pad_code  <= i_cfg_data[sldf_pkg::BYTE_W-1:0];
                sldf_pkg::REG_CMD_PREFIX: begin
                    r_codes.command_prefix <= i_cfg_data[sldf_pkg::BYTE_W-1:0];
                end
                sldf_pkg::REG_EVT_PREFIX: begin
                    r_codes.event_prefix <= i_cfg_data[sldf_pkg::BYTE_W-1:0];
                end
                sldf_pkg::REG_CTS_CODE:   r_codes.cts_code  <= i_cfg_data[sldf_pkg::BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    // accept whenever the queue has room; the back drains it independently
    assign o_ready = !q_full;
    assign accept  = i_valid && o_ready;

    sldf_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_rx_byte      (i_rx_byte),
        .i_buffer_full  (i_buffer_full),
        .i_cts_was_sent (i_cts_was_sent),
        .i_codes        (r_codes),
        .o_op           (front_op)
    );

    sldf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_op    (front_op),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_op    (head_op)
    );

    sldf_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_valid         (q_valid),
        .i_op              (head_op),
        .o_pop             (q_pop),
        .i_max_block_size  (r_max_block_size),
        .i_local_cts_limit (r_local_cts_limit),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_consumed        (o_consumed),
        .o_data_valid      (o_data_valid),
        .o_data_byte       (o_data_byte),
        .o_end_marker      (o_end_marker),
        .o_command_valid   (o_command_valid),
        .o_command_value   (o_command_value),
        .o_event_valid     (o_event_valid),
        .o_event_value     (o_event_value),
        .o_cts_received    (o_cts_received),
        .o_reply_event     (o_reply_event),
        .o_cts_due         (o_cts_due),
        .o_link_ready      (o_link_ready)
    );

endmodule

`default_nettype wire
